// ===== rtl/core/cfs_pkg.sv =====
`default_nettype none

package cfs_pkg;

  // Field widths fixed by the item formats
  localparam int DATA_W    = 32;
  localparam int SLOT_W    = 6;
  localparam int DEPTH_DEF = 64;

  // Command codes
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_DELETE = 2'd1;
  localparam logic [1:0] CMD_SEARCH = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OVER     = 2'd1;
  localparam logic [1:0] ST_UNDER    = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  typedef struct packed {
    logic [1:0]               cmd;
    logic signed [DATA_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [DATA_W-1:0] data;
    logic [SLOT_W-1:0]        slot;
    logic                     last;
  } out_item_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DEL_OUT,
    S_SCAN
  } state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic ins;      // write at tail, report ok
    logic ovf;      // report overflow
    logic und;      // report underflow
    logic del_rd;   // read oldest word, pop it
    logic del_out;  // report the popped word
    logic scan_ld;  // latch key and scan window
    logic scan;     // scan running
    logic finish;   // close the search
  } ctl_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic empty;
    logic full;
    logic scan_idle;
  } sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/cfs_ctrl.sv =====
`default_nettype none

module cfs_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [1:0]    cmd,
  input  wire cfs_pkg::sts_t sts,
  output logic               busy,
  output cfs_pkg::ctl_t      ctl
);

  cfs_pkg::state_t state;
  cfs_pkg::state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cfs_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    ctl        = '0;
    busy       = (state != cfs_pkg::S_IDLE);
    case (state)
      cfs_pkg::S_IDLE: begin
        if (start) begin
          case (cmd)
            cfs_pkg::CMD_INSERT: begin
              if (sts.full) begin
                ctl.ovf = 1'b1;
              end else begin
                ctl.ins = 1'b1;
              end
            end
            cfs_pkg::CMD_DELETE: begin
              if (sts.empty) begin
                ctl.und = 1'b1;
              end else begin
                ctl.del_rd = 1'b1;
                state_next = cfs_pkg::S_DEL_OUT;
              end
            end
            cfs_pkg::CMD_SEARCH: begin
              if (sts.empty) begin
                ctl.und = 1'b1;
              end else begin
                ctl.scan_ld = 1'b1;
                state_next  = cfs_pkg::S_SCAN;
              end
            end
            default: begin
              // unused code: no result, no change
            end
          endcase
        end
      end
      cfs_pkg::S_DEL_OUT: begin
        ctl.del_out = 1'b1;
        state_next  = cfs_pkg::S_IDLE;
      end
      cfs_pkg::S_SCAN: begin
        ctl.scan = 1'b1;
        if (sts.scan_idle) begin
          ctl.finish = 1'b1;
          state_next = cfs_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = cfs_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/cfs_dpath.sv =====
`default_nettype none

module cfs_dpath #(
  parameter int DEPTH = cfs_pkg::DEPTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic signed [cfs_pkg::DATA_W-1:0] value,
  input  wire cfs_pkg::ctl_t                     ctl,
  output cfs_pkg::sts_t                          sts,
  output logic                                   strobe,
  output cfs_pkg::out_item_t                     result
);

  localparam int ADDR_W = $clog2(DEPTH);
  localparam int OCC_W  = $clog2(DEPTH + 1);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
  localparam logic [OCC_W-1:0]  FULL_OCC  = OCC_W'(DEPTH);

  logic [cfs_pkg::DATA_W-1:0] mem [DEPTH];

  logic [ADDR_W-1:0]          head;
  logic [ADDR_W-1:0]          tail;
  logic [OCC_W-1:0]           occ;
  logic [cfs_pkg::DATA_W-1:0] key;
  logic [ADDR_W-1:0]          scan_addr;
  logic [OCC_W-1:0]           scan_left;
  logic [cfs_pkg::DATA_W-1:0] rd_data;
  logic [ADDR_W-1:0]          rd_slot;
  logic                       rd_vld;
  logic                       pend_valid;
  logic [ADDR_W-1:0]          pend_slot;

  logic                       scan_rd;
  logic                       hit;
  logic                       emit;
  cfs_pkg::out_item_t         res_next;

  function automatic logic [ADDR_W-1:0] wrap_inc(input logic [ADDR_W-1:0] a);
    return (a == LAST_ADDR) ? '0 : a + ADDR_W'(1);
  endfunction

  assign sts.empty     = (occ == '0);
  assign sts.full      = (occ == FULL_OCC);
  assign sts.scan_idle = (scan_left == '0) && !rd_vld;

  assign scan_rd = ctl.scan && (scan_left != '0);
  assign hit     = rd_vld && (rd_data == key);

  // Storage: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (ctl.ins) begin
      mem[tail] <= value;
    end
    if (ctl.del_rd) begin
      rd_data <= mem[head];
      rd_slot <= head;
    end else if (scan_rd) begin
      rd_data <= mem[scan_addr];
      rd_slot <= scan_addr;
    end
  end

  // Ring pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
      occ  <= '0;
    end else if (ctl.ins) begin
      tail <= wrap_inc(tail);
      occ  <= occ + OCC_W'(1);
    end else if (ctl.del_rd) begin
      head <= wrap_inc(head);
      occ  <= occ - OCC_W'(1);
    end
  end

  // Search scan: one read per cycle, compare in the following cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_left  <= '0;
      rd_vld     <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      rd_vld <= scan_rd;
      if (ctl.scan_ld) begin
        key        <= value;
        scan_addr  <= head;
        scan_left  <= occ;
        pend_valid <= 1'b0;
      end else if (scan_rd) begin
        scan_addr <= wrap_inc(scan_addr);
        scan_left <= scan_left - OCC_W'(1);
      end
      if (hit) begin
        pend_valid <= 1'b1;
        pend_slot  <= rd_slot;
      end
    end
  end

  // Result beat selection; a held match goes out once the next one shows up or the search closes
  always_comb begin
    emit     = 1'b0;
    res_next = '0;
    res_next.last = 1'b1;
    if (ctl.ins) begin
      emit          = 1'b1;
      res_next.data = value;
      res_next.slot = cfs_pkg::SLOT_W'(tail);
    end else if (ctl.ovf) begin
      emit            = 1'b1;
      res_next.status = cfs_pkg::ST_OVER;
    end else if (ctl.und) begin
      emit            = 1'b1;
      res_next.status = cfs_pkg::ST_UNDER;
    end else if (ctl.del_out) begin
      emit          = 1'b1;
      res_next.data = rd_data;
      res_next.slot = cfs_pkg::SLOT_W'(rd_slot);
    end else if (hit && pend_valid) begin
      emit          = 1'b1;
      res_next.data = key;
      res_next.slot = cfs_pkg::SLOT_W'(pend_slot);
      res_next.last = 1'b0;
    end else if (ctl.finish) begin
      emit = 1'b1;
      if (pend_valid) begin
        res_next.data = key;
        res_next.slot = cfs_pkg::SLOT_W'(pend_slot);
      end else begin
        res_next.status = cfs_pkg::ST_NOTFOUND;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= emit;
    end
    if (emit) begin
      result <= res_next;
    end
  end

  // Checks
  a_occ_range: assert property (@(posedge clk) disable iff (rst)
    occ <= FULL_OCC)
    else $error("fill level above depth");

  a_ptr_meet: assert property (@(posedge clk) disable iff (rst)
    (occ == '0 || occ == FULL_OCC) |-> head == tail)
    else $error("head and tail disagree with fill level");

  a_cmp_src: assert property (@(posedge clk) disable iff (rst)
    rd_vld |-> $past(ctl.scan))
    else $error("compare without a scan read");

  a_mid_ok: assert property (@(posedge clk) disable iff (rst)
    (strobe && !result.last) |-> result.status == cfs_pkg::ST_OK)
    else $error("non-final beat with error status");

  a_scan_len: assert property (@(posedge clk) disable iff (rst)
    ctl.scan |-> scan_left <= occ)
    else $error("scan window larger than fill level");

endmodule

`default_nettype wire

// ===== rtl/core/circular_fifo_with_search_top.sv =====
// Insert, overflow, underflow: result beat and next command both the cycle after accept.
// Delete: registered memory read, then S_DEL_OUT sends the word; busy there, so no new command.
// Search: busy while the scan runs, one stored word compared per cycle, match beats streamed.
// Result beats carry a one-cycle strobe; the receiver cannot stall.
// Reset (rst, synchronous) empties the ring: head, tail and fill level go to zero;
// word storage is not cleared.
`default_nettype none

module circular_fifo_with_search_top #(
  parameter int DEPTH = cfs_pkg::DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire cfs_pkg::in_item_t item,
  output logic                   busy,
  output logic                   strobe,
  output cfs_pkg::out_item_t     result
);

  cfs_pkg::ctl_t ctl;
  cfs_pkg::sts_t sts;

  cfs_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .cmd   (item.cmd),
    .sts   (sts),
    .busy  (busy),
    .ctl   (ctl)
  );

  cfs_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk    (clk),
    .rst    (rst),
    .value  (item.value),
    .ctl    (ctl),
    .sts    (sts),
    .strobe (strobe),
    .result (result)
  );

endmodule

`default_nettype wire

// ===== tb/tb_circular_fifo_with_search_top.sv =====
`default_nettype none

module tb_circular_fifo_with_search_top;

  localparam int DEPTH = cfs_pkg::DEPTH_DEF;
  localparam int LIMIT = 400000;
  localparam int MAX_REPORTS = 40;
  // cmd code with no operation behind it
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct {
    cfs_pkg::in_item_t beat;
    int unsigned       gap;
    bit                hold;  // wait for all results before sending
  } cmd_req_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  cfs_pkg::in_item_t  item = '0;
  logic               busy;
  logic               strobe;
  cfs_pkg::out_item_t result;

  circular_fifo_with_search_top #(.DEPTH(DEPTH)) i_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .item   (item),
    .busy   (busy),
    .strobe (strobe),
    .result (result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Ring model: stored words, pointers and fill level
  logic signed [cfs_pkg::DATA_W-1:0] ring [DEPTH];
  logic [cfs_pkg::SLOT_W-1:0]        rd_ptr = '0;
  logic [cfs_pkg::SLOT_W-1:0]        wr_ptr = '0;
  int                                fill = 0;

  cmd_req_t           cmd_q [$];
  cfs_pkg::out_item_t due_q [$];
  int                 outstanding = 0;
  int                 n_err = 0;
  int                 n_reports = 0;
  int                 cycles = 0;

  // coverage tallies for the summary
  int n_ins = 0, n_del = 0, n_srch = 0, n_ovf = 0, n_und = 0, n_nf = 0;
  int n_hit = 0, max_hits = 0, n_rd_wrap = 0, n_wr_wrap = 0;

  // generator-side view of the fill level
  int gen_fill = 0;
  int burst_left = 0;

  function automatic logic [cfs_pkg::SLOT_W-1:0] slot_next(
      input logic [cfs_pkg::SLOT_W-1:0] s);
    return (s == cfs_pkg::SLOT_W'(DEPTH - 1)) ? '0 : s + cfs_pkg::SLOT_W'(1);
  endfunction

  // Apply one command to the ring model, queue its results, return their count
  function automatic int ring_predict(input cfs_pkg::in_item_t b);
    cfs_pkg::out_item_t         r;
    cfs_pkg::out_item_t         prev;
    logic [cfs_pkg::SLOT_W-1:0] p;
    int                         hits;
    int                         n;
    r = '0;
    r.last = 1'b1;
    n = 1;
    hits = 0;
    case (b.cmd)
      cfs_pkg::CMD_INSERT: begin
        n_ins++;
        if (fill == DEPTH) begin
          r.status = cfs_pkg::ST_OVER;
          n_ovf++;
        end else begin
          ring[wr_ptr] = b.value;
          r.status = cfs_pkg::ST_OK;
          r.data = b.value;
          r.slot = wr_ptr;
          if (wr_ptr == cfs_pkg::SLOT_W'(DEPTH - 1)) n_wr_wrap++;
          wr_ptr = slot_next(wr_ptr);
          fill++;
        end
        due_q.push_back(r);
      end
      cfs_pkg::CMD_DELETE: begin
        n_del++;
        if (fill == 0) begin
          r.status = cfs_pkg::ST_UNDER;
          n_und++;
        end else begin
          r.status = cfs_pkg::ST_OK;
          r.data = ring[rd_ptr];
          r.slot = rd_ptr;
          if (rd_ptr == cfs_pkg::SLOT_W'(DEPTH - 1)) n_rd_wrap++;
          rd_ptr = slot_next(rd_ptr);
          fill--;
        end
        due_q.push_back(r);
      end
      cfs_pkg::CMD_SEARCH: begin
        n_srch++;
        if (fill == 0) begin
          r.status = cfs_pkg::ST_UNDER;
          n_und++;
          due_q.push_back(r);
        end else begin
          // scan oldest to newest; hold back each match until the next is known
          p = rd_ptr;
          prev = '0;
          for (int i = 0; i < fill; i++) begin
            if (ring[p] == b.value) begin
              if (hits != 0) due_q.push_back(prev);
              prev = '0;
              prev.status = cfs_pkg::ST_OK;
              prev.data = b.value;
              prev.slot = p;
              hits++;
            end
            p = slot_next(p);
          end
          if (hits == 0) begin
            r.status = cfs_pkg::ST_NOTFOUND;
            n_nf++;
            due_q.push_back(r);
          end else begin
            prev.last = 1'b1;
            due_q.push_back(prev);
            n = hits;
            n_hit += hits;
            if (hits > max_hits) max_hits = hits;
          end
        end
      end
      default: n = 0;
    endcase
    return n;
  endfunction

  // Queue one command with a random lead gap
  task automatic queue_cmd(input logic [1:0] op,
                           input logic signed [cfs_pkg::DATA_W-1:0] v,
                           input bit hold);
    cmd_req_t    q;
    int unsigned r;
    r = $urandom_range(0, 99);
    q.beat.cmd = op;
    q.beat.value = v;
    q.hold = hold;
    if (burst_left != 0) begin
      q.gap = 0;
      burst_left--;
    end else if (r < 50) begin
      q.gap = 0;
    end else if (r < 88) begin
      q.gap = $urandom_range(1, 3);
    end else if (r < 97) begin
      q.gap = $urandom_range(6, 40);
    end else begin
      q.gap = 0;
      burst_left = $urandom_range(10, 30);
    end
    cmd_q.push_back(q);
    if (op == cfs_pkg::CMD_INSERT && gen_fill < DEPTH) gen_fill++;
    if (op == cfs_pkg::CMD_DELETE && gen_fill > 0) gen_fill--;
  endtask

  // Driver: one beat per handshake, gaps and drain pauses from the queue
  always @(posedge clk) begin
    int n;
    bit take;
    if (rst) begin
      start <= 1'b0;
    end else begin
      take = 1'b0;
      if (start && !busy) begin
        n = ring_predict(item);
        outstanding += n;
      end
      if (strobe) outstanding--;
      if (!(start && busy)) begin
        if (cmd_q.size() != 0 && cmd_q[0].gap != 0) begin
          cmd_q[0].gap--;
        end else if (cmd_q.size() != 0 && !(cmd_q[0].hold && outstanding != 0)) begin
          item <= cmd_q[0].beat;
          void'(cmd_q.pop_front());
          take = 1'b1;
        end
        start <= take;
      end
    end
  end

  // Monitor: every strobed beat against the oldest expectation
  always @(posedge clk) begin
    cfs_pkg::out_item_t e;
    if (!rst && strobe) begin
      if (due_q.size() == 0) begin
        n_err++;
        if (n_reports < MAX_REPORTS) begin
          n_reports++;
          $display("%0t: unexpected result beat: status=%0d data=%h slot=%0d last=%0b",
                   $time, result.status, result.data, result.slot, result.last);
        end
      end else begin
        e = due_q.pop_front();
        if (result.status !== e.status || result.data !== e.data ||
            result.slot !== e.slot || result.last !== e.last) begin
          n_err++;
          if (n_reports < MAX_REPORTS) begin
            n_reports++;
            $display("%0t: mismatch: expected status=%0d data=%h slot=%0d last=%0b",
                     $time, e.status, e.data, e.slot, e.last);
            $display("%0t:           actual   status=%0d data=%h slot=%0d last=%0b",
                     $time, result.status, result.data, result.slot, result.last);
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles == LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due", cycles, due_q.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    logic signed [cfs_pkg::DATA_W-1:0] pool [4];
    logic signed [cfs_pkg::DATA_W-1:0] v;
    logic [1:0]                        op;
    int unsigned                       r;
    bit                                draining;
    bit                                pause_next;
    int                                ovf_tries;
    int                                und_tries;
    int                                n_rand;

    // directed: empty-buffer errors, extreme values, hits, misses, unused code
    queue_cmd(cfs_pkg::CMD_DELETE, 32'sd0, 1'b0);
    queue_cmd(cfs_pkg::CMD_SEARCH, 32'sd0, 1'b0);
    queue_cmd(cfs_pkg::CMD_INSERT, 32'sh8000_0000, 1'b0);
    queue_cmd(cfs_pkg::CMD_INSERT, 32'sh7FFF_FFFF, 1'b0);
    queue_cmd(cfs_pkg::CMD_INSERT, 32'sd0, 1'b0);
    queue_cmd(cfs_pkg::CMD_INSERT, -32'sd1, 1'b0);
    queue_cmd(cfs_pkg::CMD_INSERT, 32'sh7FFF_FFFF, 1'b0);
    queue_cmd(cfs_pkg::CMD_SEARCH, 32'sh7FFF_FFFF, 1'b0);
    queue_cmd(cfs_pkg::CMD_SEARCH, 32'sh8000_0000, 1'b0);
    queue_cmd(cfs_pkg::CMD_SEARCH, 32'sh1234_5678, 1'b0);
    queue_cmd(CMD_UNUSED, $urandom, 1'b0);
    queue_cmd(cfs_pkg::CMD_SEARCH, -32'sd1, 1'b1);
    for (int i = 0; i < 6; i++) queue_cmd(cfs_pkg::CMD_DELETE, $urandom, 1'b0);
    queue_cmd(cfs_pkg::CMD_SEARCH, 32'sd0, 1'b0);
    queue_cmd(CMD_UNUSED, $urandom, 1'b1);
    queue_cmd(cfs_pkg::CMD_INSERT, $urandom, 1'b0);

    // random: insert-heavy until full and overflowing, then delete-heavy until empty
    pool[0] = $urandom;
    pool[1] = $urandom;
    pool[2] = 32'sh7FFF_FFFF;
    pool[3] = 32'sh8000_0000;
    draining = 1'b0;
    pause_next = 1'b0;
    ovf_tries = 0;
    und_tries = 0;
    n_rand = 0;
    while (und_tries < 1 && n_rand < 170) begin
      r = $urandom_range(0, 99);
      v = ($urandom_range(0, 9) < 7) ? pool[$urandom_range(0, 3)] : $urandom;
      if (!draining) begin
        op = (r < 94) ? cfs_pkg::CMD_INSERT : (r < 98) ? cfs_pkg::CMD_SEARCH :
             cfs_pkg::CMD_DELETE;
      end else begin
        op = (r < 93) ? cfs_pkg::CMD_DELETE : (r < 94) ? cfs_pkg::CMD_INSERT :
             (r < 99) ? cfs_pkg::CMD_SEARCH : CMD_UNUSED;
      end
      if (!draining && op == cfs_pkg::CMD_INSERT && gen_fill == DEPTH) ovf_tries++;
      if (draining && op == cfs_pkg::CMD_DELETE && gen_fill == 0) und_tries++;
      queue_cmd(op, v, pause_next || ($urandom_range(0, 49) == 0));
      pause_next = 1'b0;
      if (op != CMD_UNUSED) n_rand++;
      if (!draining && ovf_tries == 2) begin
        draining = 1'b1;
        pause_next = 1'b1;
      end
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (cmd_q.size() != 0 || start || outstanding != 0) @(posedge clk);
    repeat (DEPTH + 8) @(posedge clk);

    if (due_q.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, due_q.size());
      n_err += due_q.size();
    end

    $display("covered %0d inserts (%0d overflow), %0d deletes, %0d searches (%0d matches,",
             n_ins, n_ovf, n_del, n_srch, n_hit);
    $display("  up to %0d per search, %0d misses), %0d underflows, %0d/%0d write/read wraps",
             max_hits, n_nf, n_und, n_wr_wrap, n_rd_wrap);
    if (n_err == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d errors", n_err);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
